### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every edge out of reset.
`define CBM_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Antecedent at one edge implies consequent at the next.
`define CBM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/cbm_pkg.sv
// ----------------------------------------------------------------------------
// cbm_pkg
// Shared types and constants of the cartridge bank mapper.
// ----------------------------------------------------------------------------
package cbm_pkg;

  localparam int CBM_RAM_BYTES     = 32768;
  localparam int CBM_ROM_BANK_BITS = 7;
  localparam int CBM_BANK_REG_BITS = 7;
  localparam int CBM_ROM_AW        = 21;
  localparam int CBM_BANK_OFS_BITS = 14;
  localparam int CBM_RAM_WIN_BITS  = 13;

  typedef enum logic [1:0] {
    MODE_ROM_READ = 2'd0,
    MODE_REG_WRITE = 2'd1,
    MODE_RAM_READ = 2'd2,
    MODE_RAM_WRITE = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    REG_RAM_ENABLE = 2'd0,
    REG_BANK_LOW   = 2'd1,
    REG_BANK_HIGH  = 2'd2,
    REG_BANK_MODE  = 2'd3
  } reg_sel_t;

  localparam logic [3:0] CBM_ENABLE_KEY = 4'hA;

  typedef struct packed {
    logic [CBM_ROM_AW-1:0] rom_address;
    logic                  out_of_range;
    logic                  ram_enabled_flag;
    logic                  ram_read;
  } result_t;

  typedef struct packed {
    logic re;
    logic we;
  } ram_ctl_t;

endpackage

### rtl/core/cartridge_bank_mapper_core.sv
// ----------------------------------------------------------------------------
// cartridge_bank_mapper_core
// Each transaction passes the RAM read port and stage-1 register, then the output register.
// One transaction per cycle while out_stall does not hold the output; in_stall backs up input.
// Reset clears bank state and pipeline valids; RAM contents are not cleared.
// ----------------------------------------------------------------------------
module cartridge_bank_mapper_core import cbm_pkg::*; #(
  parameter int RAM_BYTES     = CBM_RAM_BYTES,
  parameter int ROM_BANK_BITS = CBM_ROM_BANK_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            mode,
  input  logic [15:0]           address,
  input  logic [7:0]            write_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [CBM_ROM_AW-1:0] rom_address,
  output logic [7:0]            read_data,
  output logic                  out_of_range,
  output logic                  ram_enabled_flag
);

  localparam int RAM_AW = $clog2(RAM_BYTES);

  logic              accept;
  result_t           res;
  ram_ctl_t          ram_ctl;
  logic [RAM_AW-1:0] ram_index;
  logic [7:0]        ram_rdata;

  logic    s1_valid;
  result_t s1;
  logic    s1_move;

  assign s1_move  = s1_valid & (~out_valid | ~out_stall);
  assign in_stall = s1_valid & out_valid & out_stall;
  assign accept   = in_valid & ~in_stall;

  cbm_regs #(
    .RAM_BYTES     (RAM_BYTES),
    .ROM_BANK_BITS (ROM_BANK_BITS)
  ) u_regs (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .mode       (mode),
    .address    (address),
    .write_data (write_data),
    .res        (res),
    .ram_ctl    (ram_ctl),
    .ram_index  (ram_index)
  );

  cbm_ram #(
    .RAM_BYTES (RAM_BYTES)
  ) u_ram (
    .clk   (clk),
    .ctl   (ram_ctl),
    .index (ram_index),
    .wdata (write_data),
    .rdata (ram_rdata)
  );

  // one access per transaction in order; no same-entry overlap to forward
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) s1_valid <= 1'b1;
      else if (s1_move) s1_valid <= 1'b0;
      if (s1_move) out_valid <= 1'b1;
      else if (~out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) s1 <= res;
    if (s1_move) begin
      rom_address      <= s1.rom_address;
      read_data        <= s1.ram_read ? ram_rdata : 8'd0;
      out_of_range     <= s1.out_of_range;
      ram_enabled_flag <= s1.ram_enabled_flag;
    end
  end

endmodule

### rtl/core/cbm_regs.sv
// ----------------------------------------------------------------------------
// cbm_regs
// Bank control registers, access decode and cartridge RAM address mapping.
// ----------------------------------------------------------------------------
module cbm_regs import cbm_pkg::*; #(
  parameter int RAM_BYTES     = CBM_RAM_BYTES,
  parameter int ROM_BANK_BITS = CBM_ROM_BANK_BITS,
  localparam int RAM_AW       = $clog2(RAM_BYTES)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [1:0]        mode,
  input  logic [15:0]       address,
  input  logic [7:0]        write_data,
  output result_t           res,
  output ram_ctl_t          ram_ctl,
  output logic [RAM_AW-1:0] ram_index
);

  logic                         enable_flag;
  logic [CBM_BANK_REG_BITS-1:0] bank_register;
  logic [ROM_BANK_BITS-1:0]     mapped_bank;
  logic [1:0]                   ram_bank_select;
  logic                         bank_mode;

  logic                         enable_flag_next;
  logic [CBM_BANK_REG_BITS-1:0] bank_register_next;
  logic [ROM_BANK_BITS-1:0]     mapped_bank_next;
  logic [1:0]                   ram_bank_select_next;
  logic                         bank_mode_next;

  mode_t    op;
  reg_sel_t sel;
  logic     rom_ok;
  logic     ram_ok;
  logic [4:0] low_bits;
  logic [CBM_BANK_REG_BITS-1:0] bank7;
  logic [15:0] idx_sum;

  assign op     = mode_t'(mode);
  assign sel    = reg_sel_t'(address[14:13]);
  assign rom_ok = ~address[15];
  assign ram_ok = (address[15:13] == 3'd0);
  assign low_bits = (write_data[4:0] == 5'd0) ? 5'd1 : write_data[4:0];

  always_comb begin
    enable_flag_next     = enable_flag;
    bank_register_next   = bank_register;
    mapped_bank_next     = mapped_bank;
    ram_bank_select_next = ram_bank_select;
    bank_mode_next       = bank_mode;
    if (op == MODE_REG_WRITE && rom_ok) begin
      unique case (sel)
        REG_RAM_ENABLE: enable_flag_next = (write_data[3:0] == CBM_ENABLE_KEY);
        REG_BANK_LOW: begin
          bank_register_next = {bank_register[6:5], low_bits};
          mapped_bank_next   = bank_register_next[ROM_BANK_BITS-1:0];
        end
        REG_BANK_HIGH: begin
          if (bank_mode) begin
            ram_bank_select_next = write_data[1:0];
          end else begin
            bank_register_next = {write_data[1:0], bank_register[4:0]};
            mapped_bank_next   = bank_register_next[ROM_BANK_BITS-1:0];
          end
        end
        REG_BANK_MODE: bank_mode_next = write_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enable_flag     <= 1'b0;
      bank_register   <= '0;
      mapped_bank     <= ROM_BANK_BITS'(1);
      ram_bank_select <= 2'd0;
      bank_mode       <= 1'b0;
    end else if (accept) begin
      enable_flag     <= enable_flag_next;
      bank_register   <= bank_register_next;
      mapped_bank     <= mapped_bank_next;
      ram_bank_select <= ram_bank_select_next;
      bank_mode       <= bank_mode_next;
    end
  end

  assign bank7 = address[14] ? CBM_BANK_REG_BITS'(mapped_bank) : '0;

  always_comb begin
    res                  = '0;
    res.ram_enabled_flag = enable_flag_next;
    ram_ctl              = '0;
    unique case (op)
      MODE_ROM_READ: begin
        res.out_of_range = ~rom_ok;
        if (rom_ok) res.rom_address = {bank7, address[CBM_BANK_OFS_BITS-1:0]};
      end
      MODE_REG_WRITE: res.out_of_range = ~rom_ok;
      MODE_RAM_READ: begin
        res.out_of_range = ~ram_ok;
        res.ram_read     = ram_ok;
        ram_ctl.re       = ram_ok & accept;
      end
      MODE_RAM_WRITE: begin
        res.out_of_range = ~ram_ok;
        ram_ctl.we       = ram_ok & accept;
      end
      default: ;
    endcase
  end

  // bank offset plus window offset, wrapped to the RAM size (sum < 4 * RAM_BYTES)
  always_comb begin
    idx_sum = {1'b0, ram_bank_select, address[CBM_RAM_WIN_BITS-1:0]};
    for (int k = 0; k < 3; k++) begin
      if (idx_sum >= 16'(RAM_BYTES)) idx_sum = idx_sum - 16'(RAM_BYTES);
    end
  end

  assign ram_index = idx_sum[RAM_AW-1:0];

endmodule

### rtl/core/cbm_ram.sv
// ----------------------------------------------------------------------------
// cbm_ram
// Cartridge RAM, single port, registered read data.
// ----------------------------------------------------------------------------
module cbm_ram import cbm_pkg::*; #(
  parameter int RAM_BYTES = CBM_RAM_BYTES,
  localparam int RAM_AW   = $clog2(RAM_BYTES)
) (
  input  logic              clk,
  input  ram_ctl_t          ctl,
  input  logic [RAM_AW-1:0] index,
  input  logic [7:0]        wdata,
  output logic [7:0]        rdata
);

  logic [7:0] mem [RAM_BYTES];

  always_ff @(posedge clk) begin
    if (ctl.we) mem[index] <= wdata;
    if (ctl.re) rdata <= mem[index];
  end

endmodule

### rtl/core/cbm_checker.sv
// ----------------------------------------------------------------------------
// cbm_checker
// Port-level checks of the cartridge bank mapper, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cbm_checker import cbm_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_stall,
  input logic [1:0]            mode,
  input logic [15:0]           address,
  input logic [7:0]            write_data,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [CBM_ROM_AW-1:0] rom_address,
  input logic [7:0]            read_data,
  input logic                  out_of_range,
  input logic                  ram_enabled_flag
);

  `CBM_ASSERT(a_oor_zero, clk, rst, !(out_valid && out_of_range) || (rom_address == '0 && read_data == 8'd0), "out of range transaction with nonzero data")
  `CBM_ASSERT(a_one_field, clk, rst, !(out_valid && read_data != 8'd0) || (rom_address == '0 && !out_of_range), "ram data and rom address both set")
  `CBM_ASSERT(a_stall_cause, clk, rst, !in_stall || (out_valid && out_stall), "input stalled with output free")
  `CBM_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(rom_address) && $stable(read_data) && $stable(out_of_range) && $stable(ram_enabled_flag), "stalled result changed")

endmodule

bind cartridge_bank_mapper_core cbm_checker u_cbm_checker (.*);

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for cartridge_bank_mapper_core. A queue of bus
// accesses (directed corner cases, then random bank-switch, RAM and noise
// sequences) feeds a clocked driver; a clocked monitor compares each result
// transaction against a bank-state predictor updated at input acceptance.
// ----------------------------------------------------------------------------
module testbench;
  import cbm_pkg::*;

  typedef struct packed {
    mode_t       mode;
    logic [15:0] address;
    logic [7:0]  data;
  } access_t;

  typedef struct packed {
    access_t acc;
    bit      drain;
  } pending_t;

  typedef struct packed {
    logic       enable;
    logic [6:0] bank_reg;
    logic [6:0] mapped;
    logic [1:0] ram_sel;
    logic       bank_mode;
  } bank_regs_t;

  typedef struct packed {
    logic [CBM_ROM_AW-1:0] rom_address;
    logic [7:0]            read_data;
    logic                  out_of_range;
    logic                  enable_now;
  } bus_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [1:0]            mode = 2'd0;
  logic [15:0]           address = 16'd0;
  logic [7:0]            write_data = 8'd0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [CBM_ROM_AW-1:0] rom_address;
  logic [7:0]            read_data;
  logic                  out_of_range;
  logic                  ram_enabled_flag;

  pending_t    access_backlog[$];
  bus_result_t bus_results_due[$];

  bank_regs_t  gen_regs;
  bit          gen_written [CBM_RAM_BYTES];
  bank_regs_t  live_regs;
  logic [7:0]  live_ram [CBM_RAM_BYTES];
  access_t     on_bus;

  int unsigned accepted_n = 0;
  int unsigned total_items = 0;
  int unsigned mismatches = 0;
  logic [1:0]  idle_phase = 2'd0;

  cartridge_bank_mapper_core dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .mode             (mode),
    .address          (address),
    .write_data       (write_data),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .rom_address      (rom_address),
    .read_data        (read_data),
    .out_of_range     (out_of_range),
    .ram_enabled_flag (ram_enabled_flag)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic void map_bus_access(inout bank_regs_t r, input access_t t,
                                         output bus_result_t e, output bit rd,
                                         output bit wr, output logic [14:0] idx);
    logic [4:0] low;
    e   = '0;
    rd  = 1'b0;
    wr  = 1'b0;
    idx = 15'((r.ram_sel * 32'h2000 + t.address) % CBM_RAM_BYTES);
    case (t.mode)
      MODE_ROM_READ: begin
        if (t.address >= 16'h8000) e.out_of_range = 1'b1;
        else if (t.address < 16'h4000) e.rom_address = CBM_ROM_AW'(t.address);
        else e.rom_address = CBM_ROM_AW'(t.address - 16'h4000)
                             + CBM_ROM_AW'(r.mapped) * CBM_ROM_AW'(16'h4000);
      end
      MODE_REG_WRITE: begin
        if (t.address >= 16'h8000) begin
          e.out_of_range = 1'b1;
        end else begin
          case (reg_sel_t'(t.address[14:13]))
            REG_RAM_ENABLE: r.enable = (t.data[3:0] == CBM_ENABLE_KEY);
            REG_BANK_LOW: begin
              low = t.data[4:0];
              if (low == 5'd0) low = 5'd1;
              r.bank_reg = {r.bank_reg[6:5], low};
              r.mapped   = r.bank_reg & 7'((1 << CBM_ROM_BANK_BITS) - 1);
            end
            REG_BANK_HIGH: begin
              if (r.bank_mode) begin
                r.ram_sel = t.data[1:0];
              end else begin
                r.bank_reg = {t.data[1:0], r.bank_reg[4:0]};
                r.mapped   = r.bank_reg & 7'((1 << CBM_ROM_BANK_BITS) - 1);
              end
            end
            REG_BANK_MODE: r.bank_mode = t.data[0];
          endcase
        end
      end
      MODE_RAM_READ: begin
        if (t.address >= 16'h2000) e.out_of_range = 1'b1;
        else rd = 1'b1;
      end
      default: begin
        if (t.address >= 16'h2000) e.out_of_range = 1'b1;
        else wr = 1'b1;
      end
    endcase
    e.enable_now = r.enable;
  endfunction

  function automatic bank_regs_t regs_after_reset();
    bank_regs_t r;
    r        = '0;
    r.mapped = 7'd1;
    return r;
  endfunction

  // Reads of never-written RAM bytes are turned into writes.
  task automatic queue_access(input mode_t m, input logic [15:0] a, input logic [7:0] d,
                              input bit drain = 1'b0);
    access_t     t;
    bus_result_t e;
    bit          rd, wr;
    logic [14:0] idx;
    t = '{m, a, d};
    map_bus_access(gen_regs, t, e, rd, wr, idx);
    if (rd && !gen_written[idx]) begin
      t.mode = MODE_RAM_WRITE;
      wr     = 1'b1;
    end
    if (wr) gen_written[idx] = 1'b1;
    access_backlog.push_back('{t, drain});
  endtask

  function automatic logic [15:0] pick_rom_offset();
    int unsigned r;
    logic [15:0] edges [8];
    edges = '{16'h0000, 16'h1FFF, 16'h2000, 16'h3FFF, 16'h4000, 16'h5FFF, 16'h6000, 16'h7FFF};
    r = $urandom_range(0, 99);
    if (r < 10) return 16'($urandom_range(16'h8000, 16'hFFFF));
    if (r < 16) return edges[$urandom_range(0, 7)];
    return 16'($urandom_range(0, 16'h7FFF));
  endfunction

  function automatic logic [15:0] pick_ram_offset();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return 16'($urandom_range(16'h2000, 16'hFFFF));
    if (r < 55) return ($urandom_range(0, 1) ? 16'h1FF8 : 16'h0000) + 16'($urandom_range(0, 7));
    return 16'($urandom_range(0, 16'h1FFF));
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    mismatches++;
    $display("MISMATCH %s: got 0x%0h expected 0x%0h at %0t ns", what, got, want, $time);
  endtask

  always @(posedge clk) begin : driver_proc
    bus_result_t e;
    bit          rd, wr;
    logic [14:0] idx;
    int unsigned send_pct;
    pending_t    p;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        map_bus_access(live_regs, on_bus, e, rd, wr, idx);
        if (rd) e.read_data = live_ram[idx];
        if (wr) live_ram[idx] = on_bus.data;
        bus_results_due.push_back(e);
        accepted_n++;
        idle_phase <= (accepted_n < total_items / 3) ? 2'd0 :
                      (accepted_n < 2 * total_items / 3) ? 2'd1 : 2'd2;
      end
      send_pct = (idle_phase == 2'd0) ? 8 : (idle_phase == 2'd1) ? 63 : 0;
      if (!in_valid || !in_stall) begin
        if (access_backlog.size() > 0
            && !(access_backlog[0].drain && bus_results_due.size() > 0)
            && $urandom_range(0, 99) >= send_pct) begin
          p = access_backlog.pop_front();
          in_valid   <= 1'b1;
          mode       <= p.acc.mode;
          address    <= p.acc.address;
          write_data <= p.acc.data;
          on_bus     <= p.acc;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : monitor_proc
    bus_result_t e;
    int unsigned stall_pct;
    stall_pct = (idle_phase == 2'd0) ? 63 : (idle_phase == 2'd1) ? 8 : 0;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (bus_results_due.size() == 0) begin
          report_mismatch("unexpected result transaction", rom_address, 0);
        end else begin
          e = bus_results_due.pop_front();
          if (rom_address !== e.rom_address)
            report_mismatch("rom_address", rom_address, e.rom_address);
          if (read_data !== e.read_data)
            report_mismatch("read_data", read_data, e.read_data);
          if (out_of_range !== e.out_of_range)
            report_mismatch("out_of_range", out_of_range, e.out_of_range);
          if (ram_enabled_flag !== e.enable_now)
            report_mismatch("ram_enabled_flag", ram_enabled_flag, e.enable_now);
        end
      end
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  initial begin : stimulus_proc
    int unsigned kind, n, wait_n;
    logic [15:0] a;
    mode_t       m;
    gen_regs  = regs_after_reset();
    live_regs = regs_after_reset();
    foreach (gen_written[i]) gen_written[i] = 1'b0;

    // ROM window edges and out-of-range reads
    queue_access(MODE_ROM_READ, 16'h0000, 8'h00);
    queue_access(MODE_ROM_READ, 16'h3FFF, 8'hFF);
    queue_access(MODE_ROM_READ, 16'h4000, 8'h00);
    queue_access(MODE_ROM_READ, 16'h7FFF, 8'h00);
    queue_access(MODE_ROM_READ, 16'h8000, 8'h00);
    queue_access(MODE_ROM_READ, 16'hFFFF, 8'hFF);
    // RAM enable key
    queue_access(MODE_REG_WRITE, 16'h0000, 8'h0A);
    queue_access(MODE_REG_WRITE, 16'h1FFF, 8'h0B);
    queue_access(MODE_REG_WRITE, 16'h1000, 8'hFA);
    // upper bits right after reset leave the low bits at zero
    queue_access(MODE_REG_WRITE, 16'h4000, 8'h03);
    queue_access(MODE_ROM_READ, 16'h4000, 8'h00);
    // low bank zero becomes one, then the top bank
    queue_access(MODE_REG_WRITE, 16'h2000, 8'h00);
    queue_access(MODE_REG_WRITE, 16'h3FFF, 8'hFF);
    queue_access(MODE_ROM_READ, 16'h7FFF, 8'h00);
    queue_access(MODE_REG_WRITE, 16'h8000, 8'h0A);
    // RAM banking mode, bank 2
    queue_access(MODE_REG_WRITE, 16'h6000, 8'h01);
    queue_access(MODE_REG_WRITE, 16'h5FFF, 8'h02);
    queue_access(MODE_RAM_WRITE, 16'h0000, 8'hFF);
    queue_access(MODE_RAM_READ, 16'h0000, 8'h00);
    queue_access(MODE_RAM_WRITE, 16'h1FFF, 8'h00);
    queue_access(MODE_RAM_READ, 16'h1FFF, 8'hFF);
    queue_access(MODE_RAM_WRITE, 16'h2000, 8'h55);
    queue_access(MODE_RAM_READ, 16'hFFFF, 8'h00);
    queue_access(MODE_REG_WRITE, 16'h7FFF, 8'hFE);

    queue_access(MODE_ROM_READ, pick_rom_offset(), 8'($urandom), 1'b1);
    while (access_backlog.size() < 775) begin
      kind = $urandom_range(0, 9);
      if (kind <= 2) begin
        m = mode_t'($urandom_range(0, 3));
        a = (m == MODE_ROM_READ || m == MODE_REG_WRITE) ? pick_rom_offset() : pick_ram_offset();
        queue_access(m, a, 8'($urandom));
      end else if (kind <= 5) begin
        if ($urandom_range(0, 3) == 0)
          queue_access(MODE_REG_WRITE, 16'h6000 + 16'($urandom_range(0, 16'h1FFF)), 8'($urandom));
        queue_access(MODE_REG_WRITE, 16'h2000 + 16'($urandom_range(0, 16'h1FFF)), 8'($urandom));
        if ($urandom_range(0, 1))
          queue_access(MODE_REG_WRITE, 16'h4000 + 16'($urandom_range(0, 16'h1FFF)),
                       8'($urandom));
        n = $urandom_range(1, 3);
        repeat (n) queue_access(MODE_ROM_READ, 16'($urandom_range(16'h4000, 16'h7FFF)),
                                8'($urandom));
      end else if (kind <= 8) begin
        if ($urandom_range(0, 4) < 2) begin
          queue_access(MODE_REG_WRITE, 16'h6000 + 16'($urandom_range(0, 16'h1FFF)), 8'($urandom));
          queue_access(MODE_REG_WRITE, 16'h4000 + 16'($urandom_range(0, 16'h1FFF)), 8'($urandom));
        end
        if ($urandom_range(0, 1))
          queue_access(MODE_REG_WRITE, 16'($urandom_range(0, 16'h1FFF)),
                       {4'($urandom), $urandom_range(0, 1) ? CBM_ENABLE_KEY : 4'($urandom)});
        n = $urandom_range(2, 4);
        repeat (n) begin
          a = pick_ram_offset();
          if ($urandom_range(0, 2) == 0) queue_access(MODE_RAM_WRITE, a, 8'($urandom));
          queue_access(MODE_RAM_READ, a, 8'($urandom));
        end
      end else begin
        queue_access(mode_t'($urandom_range(0, 3)), 16'($urandom), 8'($urandom));
      end
      if (access_backlog.size() >= 400 && access_backlog.size() < 404)
        access_backlog[access_backlog.size() - 1].drain = 1'b1;
    end
    total_items = access_backlog.size();

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (access_backlog.size() > 0 || in_valid) @(posedge clk);
    wait_n = 0;
    while (bus_results_due.size() > 0 && wait_n < 5000) begin
      @(posedge clk);
      wait_n++;
    end
    repeat (10) @(posedge clk);
    if (bus_results_due.size() > 0)
      report_mismatch("results never delivered", 0, bus_results_due.size());
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin : watchdog_proc
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
